>>> design/bpe_pkg.sv
package bpe_pkg;

  // Table geometry
  localparam int MaxDegree  = 7;
  localparam int Dim        = MaxDegree + 1;
  localparam int IdxW       = $clog2(Dim);
  localparam int TableDepth = Dim * Dim;
  localparam int AddrW      = 2 * IdxW;

  // Word formats
  localparam int DataW     = 32;
  localparam int NormW     = 31;
  localparam int FracBits  = 30;
  localparam int NormShift = 10;
  localparam logic [NormW-1:0] InvNormReset = NormW'(1) << 24;

  // Shared multiply unit: magnitudes of OpW bits, one DigitW slice of b per cycle
  localparam int OpW       = 48;
  localparam int DigitW    = 16;
  localparam int NumDigits = OpW / DigitW;
  localparam int DigitSelW = $clog2(NumDigits);
  localparam int ProdW     = 2 * OpW;
  localparam int MagW      = 56;
  localparam int ValW      = MagW + 1;
  localparam logic [DigitSelW-1:0] LastDigit = DigitSelW'(NumDigits - 1);
  localparam logic [ProdW-1:0] RndQ30  = ProdW'(1) << (FracBits - 1);
  localparam logic [ProdW-1:0] RndNorm = ProdW'(1) << (NormShift - 1);
  localparam logic signed [ValW-1:0] OneQ30 = ValW'(1) << FracBits;

  // Configuration port
  localparam int PaddrW   = 5;
  localparam int RegIdxW  = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegMeanRange     = 3'd0;
  localparam logic [RegIdxW-1:0] RegMeanAzimuth   = 3'd1;
  localparam logic [RegIdxW-1:0] RegInvNormRange  = 3'd2;
  localparam logic [RegIdxW-1:0] RegInvNormAzim   = 3'd3;
  localparam logic [RegIdxW-1:0] RegRangeDegree   = 3'd4;
  localparam logic [RegIdxW-1:0] RegAzimuthDegree = 3'd5;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_EVAL  = 2'd2
  } action_e;

  typedef struct packed {
    logic             start;
    logic             q30;
    logic             neg;
    logic [OpW-1:0]   a;
    logic [OpW-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [ValW-1:0] value;
  } mul_rsp_t;

  function automatic logic [OpW-1:0] mag_of(input logic signed [ValW-1:0] v);
    logic signed [ValW-1:0] m;
    m = v[ValW-1] ? -v : v;
    return m[OpW-1:0];
  endfunction

endpackage

>>> design/bpe_ram.sv
module bpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bpe_mul.sv
module bpe_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpe_pkg::mul_req_t  req_i,
  output bpe_pkg::mul_rsp_t  rsp_o
);

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND, M_NEG} mstate_e;
  typedef logic [bpe_pkg::ProdW-1:0] prod_t;
  typedef logic [bpe_pkg::MagW-1:0] mag_t;
  typedef logic signed [bpe_pkg::ValW-1:0] val_t;

  mstate_e                        state_q;
  logic [bpe_pkg::OpW-1:0]        a_q, b_q;
  logic                           neg_q, q30_q, done_q;
  logic [bpe_pkg::DigitSelW-1:0]  dig_q;
  prod_t                          prod_q;
  mag_t                           mag_q;
  val_t                           res_q;

  logic [bpe_pkg::DigitW-1:0]     digit;
  prod_t                          part, part_sh, rounded, shifted;

  // One slice of b per cycle, weighted by its position
  assign digit   = b_q[bpe_pkg::DigitW*dig_q +: bpe_pkg::DigitW];
  assign part    = prod_t'(a_q) * prod_t'(digit);
  assign part_sh = part << (bpe_pkg::DigitW * dig_q);
  assign rounded = prod_q + (q30_q ? bpe_pkg::RndQ30 : bpe_pkg::RndNorm);
  assign shifted = q30_q ? (rounded >> bpe_pkg::FracBits) : (rounded >> bpe_pkg::NormShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      neg_q   <= 1'b0;
      q30_q   <= 1'b0;
      dig_q   <= '0;
      prod_q  <= '0;
      mag_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == M_NEG);
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            neg_q   <= req_i.neg;
            q30_q   <= req_i.q30;
            dig_q   <= '0;
            prod_q  <= '0;
            state_q <= M_ACC;
          end
        end
        M_ACC: begin
          prod_q <= prod_q + part_sh;
          dig_q  <= dig_q + 1'b1;
          if (dig_q == bpe_pkg::LastDigit) begin
            state_q <= M_RND;
          end
        end
        M_RND: begin
          // round the magnitude, ties away from zero once the sign goes back on
          mag_q   <= mag_t'(shifted);
          state_q <= M_NEG;
        end
        M_NEG: begin
          res_q   <= neg_q ? -val_t'(mag_q) : val_t'(mag_q);
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o.busy  = (state_q != M_IDLE);
  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

endmodule

>>> design/bivariate_polynomial_evaluator_core.sv
// Coefficient write: no result word; the sequencer stays idle.
// Coefficient read: the table word passes S_RDATA and S_DONE into the output register.
// Evaluation: every product passes the one shared multiply unit, one request at a time.
// One item at a time; the next is accepted while a result word waits at the output.
// Reset clears the table (per-entry valid bits), the registers to their defaults, all control.
module bivariate_polynomial_evaluator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       action_i,
  input  logic [bpe_pkg::IdxW-1:0]         azimuth_index_i,
  input  logic [bpe_pkg::IdxW-1:0]         range_index_i,
  input  logic signed [bpe_pkg::DataW-1:0] coeff_value_i,
  input  logic signed [bpe_pkg::DataW-1:0] azimuth_coord_i,
  input  logic signed [bpe_pkg::DataW-1:0] range_coord_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bpe_pkg::DataW-1:0] result_value_o,
  output logic                             saturated_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpe_pkg::PaddrW-1:0]       paddr,
  input  logic [bpe_pkg::DataW-1:0]        pwdata,
  output logic [bpe_pkg::DataW-1:0]        prdata,
  output logic                             pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDATA, S_NORM_Y, S_NORM_X, S_XPOW, S_SCALE, S_TERM, S_YPOW, S_FIN, S_DONE
  } state_e;
  typedef logic signed [bpe_pkg::ValW-1:0]  val_t;
  typedef logic signed [bpe_pkg::DataW:0]   diff_t;
  typedef logic [bpe_pkg::OpW-1:0]          op_t;

  localparam val_t ClipHi = (val_t'(1) <<< (bpe_pkg::DataW - 1)) - val_t'(1);
  localparam val_t ClipLo = -(val_t'(1) <<< (bpe_pkg::DataW - 1));

  function automatic logic [bpe_pkg::DataW:0] clip_word(input val_t v);
    logic [bpe_pkg::DataW:0] r;
    if (v > ClipHi) begin
      r = {1'b1, ClipHi[bpe_pkg::DataW-1:0]};
    end else if (v < ClipLo) begin
      r = {1'b1, ClipLo[bpe_pkg::DataW-1:0]};
    end else begin
      r = {1'b0, v[bpe_pkg::DataW-1:0]};
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [bpe_pkg::DataW-1:0] mean_rng_q, mean_az_q;
  logic [bpe_pkg::NormW-1:0]        inv_rng_q, inv_az_q;
  logic [bpe_pkg::IdxW-1:0]         rdeg_q, adeg_q;
  logic                             cfg_we;
  logic [bpe_pkg::RegIdxW-1:0]      reg_idx;

  // Sequencer state
  state_e                           state_q;
  logic                             wait_q, sat_q, coef_ok_q;
  logic [bpe_pkg::TableDepth-1:0]   valid_q;
  diff_t                            dy_q, dx_q;
  logic signed [bpe_pkg::DataW-1:0] x_q, y_q;
  val_t                             xp_q [bpe_pkg::Dim];
  val_t                             xlast_q, ypow_q, scale_q, acc_q;
  logic [bpe_pkg::IdxW-1:0]         k_q, a_q, r_q;
  logic signed [bpe_pkg::DataW-1:0] pend_val_q, out_val_q;
  logic                             pend_sat_q, out_valid_q, out_sat_q;

  logic                             accept, op_state, issue;
  logic                             ram_we, ram_re;
  logic [bpe_pkg::AddrW-1:0]        in_addr, ev_addr, ram_raddr;
  logic [bpe_pkg::DataW-1:0]        ram_rdata;
  val_t                             coef_v;
  logic [bpe_pkg::DataW:0]          norm_clip, acc_clip;
  bpe_pkg::mul_req_t                mul_req;
  bpe_pkg::mul_rsp_t                mul_rsp;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[bpe_pkg::PaddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_rng_q <= '0;
      mean_az_q  <= '0;
      inv_rng_q  <= bpe_pkg::InvNormReset;
      inv_az_q   <= bpe_pkg::InvNormReset;
      rdeg_q     <= '0;
      adeg_q     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        bpe_pkg::RegMeanRange:     mean_rng_q <= pwdata;
        bpe_pkg::RegMeanAzimuth:   mean_az_q  <= pwdata;
        bpe_pkg::RegInvNormRange:  inv_rng_q  <= pwdata[bpe_pkg::NormW-1:0];
        bpe_pkg::RegInvNormAzim:   inv_az_q   <= pwdata[bpe_pkg::NormW-1:0];
        bpe_pkg::RegRangeDegree:   rdeg_q     <= pwdata[bpe_pkg::IdxW-1:0];
        bpe_pkg::RegAzimuthDegree: adeg_q     <= pwdata[bpe_pkg::IdxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bpe_pkg::RegMeanRange:     prdata = mean_rng_q;
      bpe_pkg::RegMeanAzimuth:   prdata = mean_az_q;
      bpe_pkg::RegInvNormRange:  prdata = {{(bpe_pkg::DataW-bpe_pkg::NormW){1'b0}}, inv_rng_q};
      bpe_pkg::RegInvNormAzim:   prdata = {{(bpe_pkg::DataW-bpe_pkg::NormW){1'b0}}, inv_az_q};
      bpe_pkg::RegRangeDegree:   prdata = {{(bpe_pkg::DataW-bpe_pkg::IdxW){1'b0}}, rdeg_q};
      bpe_pkg::RegAzimuthDegree: prdata = {{(bpe_pkg::DataW-bpe_pkg::IdxW){1'b0}}, adeg_q};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- coefficient table ----------------
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_addr    = {azimuth_index_i, range_index_i};
  assign ev_addr    = {a_q, r_q};
  assign ram_we     = accept && (action_i == bpe_pkg::ACT_WRITE);

  assign op_state = (state_q == S_NORM_Y) || (state_q == S_NORM_X) || (state_q == S_XPOW) ||
                    (state_q == S_SCALE)  || (state_q == S_TERM)   || (state_q == S_YPOW);
  assign issue    = op_state && !wait_q;

  assign ram_re    = (accept && (action_i == bpe_pkg::ACT_READ)) ||
                     ((state_q == S_SCALE) && !wait_q);
  assign ram_raddr = (state_q == S_IDLE) ? in_addr : ev_addr;

  bpe_ram #(
    .Width (bpe_pkg::DataW),
    .Depth (bpe_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_addr),
    .wdata_i (coeff_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an entry never written reads as zero
  assign coef_v = coef_ok_q ? val_t'(signed'(ram_rdata)) : '0;

  // ---------------- shared multiply unit ----------------
  always_comb begin
    mul_req       = '0;
    mul_req.start = issue;
    unique case (state_q)
      S_NORM_Y: begin
        mul_req.a   = bpe_pkg::mag_of(val_t'(dy_q));
        mul_req.b   = op_t'(inv_az_q);
        mul_req.neg = dy_q[bpe_pkg::DataW];
      end
      S_NORM_X: begin
        mul_req.a   = bpe_pkg::mag_of(val_t'(dx_q));
        mul_req.b   = op_t'(inv_rng_q);
        mul_req.neg = dx_q[bpe_pkg::DataW];
      end
      S_XPOW: begin
        mul_req.q30 = 1'b1;
        mul_req.a   = bpe_pkg::mag_of(xlast_q);
        mul_req.b   = bpe_pkg::mag_of(val_t'(x_q));
        mul_req.neg = xlast_q[bpe_pkg::ValW-1] ^ x_q[bpe_pkg::DataW-1];
      end
      S_SCALE: begin
        mul_req.q30 = 1'b1;
        mul_req.a   = bpe_pkg::mag_of(ypow_q);
        mul_req.b   = bpe_pkg::mag_of(xp_q[r_q]);
        mul_req.neg = ypow_q[bpe_pkg::ValW-1] ^ xp_q[r_q][bpe_pkg::ValW-1];
      end
      S_TERM: begin
        mul_req.q30 = 1'b1;
        mul_req.a   = bpe_pkg::mag_of(scale_q);
        mul_req.b   = bpe_pkg::mag_of(coef_v);
        mul_req.neg = scale_q[bpe_pkg::ValW-1] ^ coef_v[bpe_pkg::ValW-1];
      end
      S_YPOW: begin
        mul_req.q30 = 1'b1;
        mul_req.a   = bpe_pkg::mag_of(ypow_q);
        mul_req.b   = bpe_pkg::mag_of(val_t'(y_q));
        mul_req.neg = ypow_q[bpe_pkg::ValW-1] ^ y_q[bpe_pkg::DataW-1];
      end
      default: ;
    endcase
  end

  bpe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign norm_clip = clip_word(mul_rsp.value);
  assign acc_clip  = clip_word(acc_q);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      sat_q       <= 1'b0;
      coef_ok_q   <= 1'b0;
      valid_q     <= '0;
      dy_q        <= '0;
      dx_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      xp_q        <= '{default: '0};
      xlast_q     <= '0;
      ypow_q      <= '0;
      scale_q     <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      a_q         <= '0;
      r_q         <= '0;
      pend_val_q  <= '0;
      pend_sat_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        valid_q[in_addr] <= 1'b1;
      end
      if (issue) begin
        wait_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (action_i)
              bpe_pkg::ACT_READ: begin
                coef_ok_q <= valid_q[in_addr];
                state_q   <= S_RDATA;
              end
              bpe_pkg::ACT_EVAL: begin
                dy_q    <= diff_t'(azimuth_coord_i) - diff_t'(mean_az_q);
                dx_q    <= diff_t'(range_coord_i) - diff_t'(mean_rng_q);
                sat_q   <= 1'b0;
                acc_q   <= '0;
                state_q <= S_NORM_Y;
              end
              default: ;
            endcase
          end
        end
        S_RDATA: begin
          pend_val_q <= coef_v[bpe_pkg::DataW-1:0];
          pend_sat_q <= 1'b0;
          state_q    <= S_DONE;
        end
        S_NORM_Y: begin
          if (mul_rsp.done) begin
            wait_q  <= 1'b0;
            y_q     <= norm_clip[bpe_pkg::DataW-1:0];
            sat_q   <= sat_q | norm_clip[bpe_pkg::DataW];
            state_q <= S_NORM_X;
          end
        end
        S_NORM_X: begin
          if (mul_rsp.done) begin
            wait_q  <= 1'b0;
            x_q     <= norm_clip[bpe_pkg::DataW-1:0];
            sat_q   <= sat_q | norm_clip[bpe_pkg::DataW];
            xp_q[0] <= bpe_pkg::OneQ30;
            xlast_q <= bpe_pkg::OneQ30;
            ypow_q  <= bpe_pkg::OneQ30;
            k_q     <= bpe_pkg::IdxW'(1);
            a_q     <= '0;
            r_q     <= '0;
            state_q <= (rdeg_q == '0) ? S_SCALE : S_XPOW;
          end
        end
        S_XPOW: begin
          // build the range powers once; every azimuth row reuses them
          if (mul_rsp.done) begin
            wait_q       <= 1'b0;
            xp_q[k_q]    <= mul_rsp.value;
            xlast_q      <= mul_rsp.value;
            k_q          <= k_q + 1'b1;
            if (k_q == rdeg_q) begin
              state_q <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (issue) begin
            coef_ok_q <= valid_q[ev_addr];
          end
          if (mul_rsp.done) begin
            wait_q  <= 1'b0;
            scale_q <= mul_rsp.value;
            state_q <= S_TERM;
          end
        end
        S_TERM: begin
          if (mul_rsp.done) begin
            wait_q <= 1'b0;
            acc_q  <= acc_q + mul_rsp.value;
            if (r_q != rdeg_q) begin
              r_q     <= r_q + 1'b1;
              state_q <= S_SCALE;
            end else if (a_q != adeg_q) begin
              state_q <= S_YPOW;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_YPOW: begin
          if (mul_rsp.done) begin
            wait_q  <= 1'b0;
            ypow_q  <= mul_rsp.value;
            a_q     <= a_q + 1'b1;
            r_q     <= '0;
            state_q <= S_SCALE;
          end
        end
        S_FIN: begin
          pend_val_q <= acc_clip[bpe_pkg::DataW-1:0];
          pend_sat_q <= sat_q | acc_clip[bpe_pkg::DataW];
          state_q    <= S_DONE;
        end
        S_DONE: begin
          // hold the word until the output register frees up
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= pend_val_q;
            out_sat_q   <= pend_sat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign saturated_o    = out_sat_q;

`ifndef SYNTH
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> wait_q)
    else $error("multiply result arrived with no request outstanding");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiply request issued while the unit is busy");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == bpe_pkg::ACT_WRITE)) |=> (state_q == S_IDLE))
    else $error("coefficient write left the sequencer busy");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) |=>
      (out_valid_q && (state_q == S_IDLE)))
    else $error("pending result word not moved to the output");
`endif

endmodule

>>> dv/tb.sv
module tb;
  import bpe_pkg::*;

  localparam logic [1:0] ActNoop = 2'd3;
  localparam logic signed [63:0] Int64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] UnitQ30 = 64'sd1 <<< FracBits;
  localparam logic signed [63:0] ResMax = 64'sd2147483647;
  localparam logic signed [63:0] ResMin = -64'sd2147483648;
  localparam int RandPhases = 20;
  localparam int PhaseItems = 96;
  localparam int DrainCycles = 24;
  localparam int MaxPrinted = 100;

  typedef struct packed {
    logic [1:0]              act;
    logic [IdxW-1:0]         az_idx;
    logic [IdxW-1:0]         rg_idx;
    logic signed [DataW-1:0] coeff;
    logic signed [DataW-1:0] az;
    logic signed [DataW-1:0] rg;
  } request_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    sat;
  } answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              action_i = '0;
  logic [IdxW-1:0]         azimuth_index_i = '0;
  logic [IdxW-1:0]         range_index_i = '0;
  logic signed [DataW-1:0] coeff_value_i = '0;
  logic signed [DataW-1:0] azimuth_coord_i = '0;
  logic signed [DataW-1:0] range_coord_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] result_value_o;
  logic                    saturated_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PaddrW-1:0]       paddr = '0;
  logic [DataW-1:0]        pwdata = '0;
  logic [DataW-1:0]        prdata;
  logic                    pready;

  // shadow of the block's registers and coefficient table
  logic signed [DataW-1:0] cfg_mean_rg = '0;
  logic signed [DataW-1:0] cfg_mean_az = '0;
  logic [NormW-1:0]        cfg_inv_rg = InvNormReset;
  logic [NormW-1:0]        cfg_inv_az = InvNormReset;
  logic [IdxW-1:0]         cfg_deg_rg = '0;
  logic [IdxW-1:0]         cfg_deg_az = '0;
  logic signed [DataW-1:0] coef_table [Dim][Dim] = '{default: '0};

  request_t requests[$];
  answer_t  answers[$];
  request_t in_word = '0;
  int       in_wait = 0;
  int       out_wait = 0;
  bit       in_gaps = 1'b1;
  bit       out_gaps = 1'b1;
  int       errors = 0;

  bivariate_polynomial_evaluator_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .azimuth_index_i(azimuth_index_i),
    .range_index_i  (range_index_i),
    .coeff_value_i  (coeff_value_i),
    .azimuth_coord_i(azimuth_coord_i),
    .range_coord_i  (range_coord_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // (a*b) >> 30, round half away from zero, magnitude clipped to int64 max
  function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [63:0]        ma, mb;
    logic [127:0]       prod;
    logic signed [63:0] mag;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    prod = 128'(ma) * 128'(mb) + (128'd1 << (FracBits - 1));
    prod = prod >> FracBits;
    mag = (prod > 128'h7FFF_FFFF_FFFF_FFFF) ? Int64Max : $signed(prod[63:0]);
    return (a[63] ^ b[63]) ? -mag : mag;
  endfunction

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Int64Max)) return Int64Max;
    if (s < -65'(Int64Max)) return -Int64Max;
    return $signed(s[63:0]);
  endfunction

  // ((coord - mean) * inv) >> 10, rounded, as Q2.30, clipped to 32 bits signed
  function automatic logic signed [63:0] norm_coord(input logic signed [DataW-1:0] coord,
                                                    input logic signed [DataW-1:0] mean,
                                                    input logic [NormW-1:0] inv,
                                                    output logic clip);
    logic signed [63:0] diff;
    logic [63:0]        mag, r;
    clip = 1'b0;
    diff = 64'(coord) - 64'(mean);
    mag = diff[63] ? -diff : diff;
    r = (mag * 64'(inv) + 64'd512) >> NormShift;
    if (diff[63]) begin
      if (r > 64'h8000_0000) begin
        clip = 1'b1;
        return -64'sh8000_0000;
      end
      return -$signed(r);
    end
    if (r > 64'h7FFF_FFFF) begin
      clip = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    return $signed(r);
  endfunction

  // apply one accepted word to the shadow table and queue its answer
  function automatic void apply_request(input request_t rq);
    logic signed [63:0] x, y, xpow, ypow, scale, acc, cval;
    logic               clip_x, clip_y, sat;
    int                 ai, ri;
    answer_t            ans;
    case (rq.act)
      ACT_WRITE: coef_table[rq.az_idx][rq.rg_idx] = rq.coeff;
      ACT_READ: begin
        ans.value = coef_table[rq.az_idx][rq.rg_idx];
        ans.sat = 1'b0;
        answers.push_back(ans);
      end
      ACT_EVAL: begin
        y = norm_coord(rq.az, cfg_mean_az, cfg_inv_az, clip_y);
        x = norm_coord(rq.rg, cfg_mean_rg, cfg_inv_rg, clip_x);
        sat = clip_x | clip_y;
        acc = '0;
        ypow = UnitQ30;
        for (ai = 0; ai <= int'(cfg_deg_az); ai++) begin
          xpow = UnitQ30;
          for (ri = 0; ri <= int'(cfg_deg_rg); ri++) begin
            scale = mul_round(ypow, xpow);
            cval = 64'(coef_table[ai][ri]);
            acc = sat_sum(acc, mul_round(scale, cval));
            xpow = mul_round(xpow, x);
          end
          ypow = mul_round(ypow, y);
        end
        if (acc > ResMax) begin
          acc = ResMax;
          sat = 1'b1;
        end else if (acc < ResMin) begin
          acc = ResMin;
          sat = 1'b1;
        end
        ans.value = acc[31:0];
        ans.sat = sat;
        answers.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MaxPrinted) $display("%0t mismatch: %s", $time, what);
  endtask

  // input side: hold a stalled word, otherwise idle or advance
  always @(posedge clk_i) begin : drive
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_wait <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_request(in_word);
      if (!in_valid_i || !in_stall_o) begin
        if (in_wait != 0) begin
          in_wait <= in_wait - 1;
          in_valid_i <= 1'b0;
        end else if (requests.size() != 0) begin
          nxt = requests.pop_front();
          in_word <= nxt;
          action_i <= nxt.act;
          azimuth_index_i <= nxt.az_idx;
          range_index_i <= nxt.rg_idx;
          coeff_value_i <= nxt.coeff;
          azimuth_coord_i <= nxt.az;
          range_coord_i <= nxt.rg;
          in_valid_i <= 1'b1;
          in_wait <= in_gaps ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: check each accepted word, then stall for a drawn count
  always @(posedge clk_i) begin : watch
    answer_t want;
    int      hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", result_value_o));
      end else begin
        want = answers.pop_front();
        if (result_value_o !== want.value)
          report_mismatch($sformatf("result_value %h, expected %h",
                                    result_value_o, want.value));
        if (saturated_o !== want.sat)
          report_mismatch($sformatf("saturated %b, expected %b", saturated_o, want.sat));
      end
      hold = out_gaps ? $urandom_range(0, 7) : 0;
      out_wait <= hold;
      out_stall_i <= (hold != 0);
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
      out_stall_i <= (out_wait != 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegMeanRange:     cfg_mean_rg = val;
      RegMeanAzimuth:   cfg_mean_az = val;
      RegInvNormRange:  cfg_inv_rg = val[NormW-1:0];
      RegInvNormAzim:   cfg_inv_az = val[NormW-1:0];
      RegRangeDegree:   cfg_deg_rg = val[IdxW-1:0];
      RegAzimuthDegree: cfg_deg_az = val[IdxW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [DataW-1:0] mean_rg, input logic [DataW-1:0] mean_az,
                           input logic [DataW-1:0] inv_rg, input logic [DataW-1:0] inv_az,
                           input logic [DataW-1:0] deg_rg, input logic [DataW-1:0] deg_az);
    write_reg(RegMeanRange, mean_rg);
    write_reg(RegMeanAzimuth, mean_az);
    write_reg(RegInvNormRange, inv_rg);
    write_reg(RegInvNormAzim, inv_az);
    write_reg(RegRangeDegree, deg_rg);
    write_reg(RegAzimuthDegree, deg_az);
  endtask

  // drain all words and results, then let a write or no-op word settle
  task automatic wait_idle();
    while (requests.size() != 0 || in_valid_i || answers.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void add_item(input logic [1:0] act, input logic [IdxW-1:0] ai,
                                   input logic [IdxW-1:0] ri, input logic [DataW-1:0] cv,
                                   input logic [DataW-1:0] az, input logic [DataW-1:0] rg);
    request_t rq;
    rq.act = act;
    rq.az_idx = ai;
    rq.rg_idx = ri;
    rq.coeff = cv;
    rq.az = az;
    rq.rg = rg;
    requests.push_back(rq);
  endfunction

  // random signed value with a random magnitude range
  function automatic logic [DataW-1:0] spread();
    logic signed [DataW-1:0] v;
    v = $signed($urandom);
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [DataW-1:0] pick_mean();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // upper bit is junk, the register keeps 31 bits
  function automatic logic [DataW-1:0] pick_inv();
    logic [NormW-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = 31'h7FFF_FFFF;
      2:       v = 31'($urandom_range(1, 255));
      3, 4:    v = 31'($urandom_range(1, 32'h7FFF_FFFF));
      default: v = 31'($urandom_range(32'h0010_0000, 32'h0800_0000));
    endcase
    return {1'($urandom_range(0, 1)), v};
  endfunction

  initial begin : stimulus
    int               k, ph, pick;
    bit               wide;
    logic [1:0]       act;
    logic [IdxW-1:0]  ai, ri;
    logic [DataW-1:0] cv, az, rg;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: table starts empty, degree 0, default inverse norms
    add_item(ACT_READ, 3'd0, 3'd0, '0, '0, '0);
    add_item(ACT_WRITE, 3'd0, 3'd0, 32'h7FFF_FFFF, '0, '0);
    add_item(ACT_WRITE, 3'd7, 3'd7, 32'h8000_0000, '0, '0);
    add_item(ACT_WRITE, 3'd3, 3'd5, 32'hFFFF_FFFF, '0, '0);
    add_item(ActNoop, 3'd2, 3'd2, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(ACT_READ, 3'd0, 3'd0, '0, '0, '0);
    add_item(ACT_READ, 3'd7, 3'd7, '0, '0, '0);
    add_item(ACT_READ, 3'd3, 3'd5, '0, '0, '0);
    add_item(ACT_READ, 3'd2, 3'd2, '0, '0, '0);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, '0, '0);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(ACT_WRITE, 3'd0, 3'd0, 32'h0001_0000, '0, '0);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h0000_8000, 32'hFFFF_8000);
    wait_idle();

    // extreme means and norms at full degree
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'd7, 32'd7);
    add_item(ACT_WRITE, 3'd0, 3'd1, 32'h7FFF_FFFF, '0, '0);
    add_item(ACT_WRITE, 3'd1, 3'd0, 32'h8000_0000, '0, '0);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h8000_0001, 32'h7FFF_FFFE);
    wait_idle();

    // zero inverse norms flatten both coordinates
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'd0,
              32'hFFFF_FFFF);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, $urandom, $urandom);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(ACT_READ, 3'd0, 3'd1, '0, '0, '0);
    add_item(ACT_WRITE, 3'd7, 3'd0, 32'h7FFF_FFFF, '0, '0);
    add_item(ACT_EVAL, 3'd0, 3'd0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    for (ph = 0; ph < RandPhases; ph++) begin
      wide = ($urandom_range(0, 3) == 0);
      configure(pick_mean(), pick_mean(), pick_inv(), pick_inv(),
                {29'($urandom), 3'(wide ? $urandom_range(0, 7) : $urandom_range(0, 3))},
                {29'($urandom), 3'(wide ? $urandom_range(0, 7) : $urandom_range(0, 3))});
      in_gaps = ($urandom_range(0, 2) != 0);
      out_gaps = ($urandom_range(0, 2) != 0);
      k = 0;
      while (k < PhaseItems) begin
        pick = $urandom_range(0, 99);
        // favor table entries the current degrees actually use
        ai = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, cfg_deg_az)) : 3'($urandom);
        ri = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, cfg_deg_rg)) : 3'($urandom);
        cv = ($urandom_range(0, 3) == 0) ? $urandom : spread();
        az = ($urandom_range(0, 7) == 0) ? $urandom : cfg_mean_az + spread();
        rg = ($urandom_range(0, 7) == 0) ? $urandom : cfg_mean_rg + spread();
        if (pick < 35) act = ACT_WRITE;
        else if (pick < 57) act = ACT_READ;
        else if (pick < 97) act = ACT_EVAL;
        else act = ActNoop;
        add_item(act, ai, ri, cv, az, rg);
        if (act != ActNoop) k++;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("** bivariate_polynomial_evaluator_core: PASSED **");
    end else begin
      $display("** bivariate_polynomial_evaluator_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("** bivariate_polynomial_evaluator_core: FAILED **");
    $finish;
  end

endmodule
